// ===== rtl/core/scpp_pkg.sv =====
package scpp_pkg;

  localparam logic [7:0] StartCode = 8'd255;
  localparam logic [7:0] CmdAcw    = 8'd1;
  localparam logic [7:0] CmdCw     = 8'd2;
  localparam logic [7:0] CmdPos    = 8'd5;
  localparam logic [7:0] EscLow    = 8'd1;
  localparam logic [7:0] EscHigh   = 8'd2;
  localparam logic [7:0] EscBoth   = 8'd3;
  localparam logic [7:0] ForcedByte = 8'd255;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_HIGH = 3'd1,
    PH_LOW  = 3'd2,
    PH_ESC  = 3'd3,
    PH_DONE = 3'd4
  } scpp_phase_e;

  typedef enum logic [1:0] {
    MODE_ACW = 2'd0,
    MODE_CW  = 2'd1,
    MODE_POS = 2'd2
  } scpp_mode_e;

  typedef struct packed {
    scpp_phase_e phase;
    logic        start_seen;
    scpp_mode_e  mode;
    logic [7:0]  high_byte;
    logic [7:0]  low_byte;
  } scpp_state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] data_word;
  } scpp_result_t;

endpackage

// ===== rtl/core/scpp_in_if.sv =====
interface scpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/scpp_out_if.sv =====
interface scpp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] data_word;

  modport source (output valid, output command, output data_word, input ready);
  modport sink   (input valid, input command, input data_word, output ready);
endinterface

// ===== rtl/core/scpp_step.sv =====
module scpp_step
  import scpp_pkg::*;
(
  input  scpp_state_t  state_i,
  input  logic [7:0]   byte_i,
  output scpp_state_t  state_o,
  output logic         emit_o,
  output scpp_result_t result_o
);

  logic       is_cmd;
  logic [7:0] esc_high;
  logic [7:0] esc_low;

  assign is_cmd = (byte_i == CmdAcw) || (byte_i == CmdCw) || (byte_i == CmdPos);

  // escape fixups
  always_comb begin
    esc_high = state_i.high_byte;
    esc_low  = state_i.low_byte;
    case (byte_i)
      EscLow:  esc_low = ForcedByte;
      EscHigh: esc_high = ForcedByte;
      EscBoth: begin
        esc_high = ForcedByte;
        esc_low  = ForcedByte;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_o = state_i;
    emit_o  = 1'b0;
    if (byte_i == StartCode || state_i.phase == PH_DONE) begin
      state_o.phase      = PH_IDLE;
      state_o.start_seen = 1'b1;
    end else if (is_cmd && state_i.phase == PH_IDLE && state_i.start_seen) begin
      state_o.start_seen = 1'b0;
      state_o.phase      = PH_HIGH;
      if (byte_i == CmdAcw) begin
        state_o.mode = MODE_ACW;
      end else if (byte_i == CmdCw) begin
        state_o.mode = MODE_CW;
      end else begin
        state_o.mode = MODE_POS;
      end
    end else begin
      unique case (state_i.phase)
        PH_HIGH: begin
          state_o.high_byte = byte_i;
          state_o.phase     = PH_LOW;
        end
        PH_LOW: begin
          state_o.low_byte = byte_i;
          state_o.phase    = PH_ESC;
        end
        PH_ESC: begin
          state_o.high_byte = esc_high;
          state_o.low_byte  = esc_low;
          state_o.phase     = PH_DONE;
          emit_o            = 1'b1;
        end
        default: state_o.start_seen = 1'b0;
      endcase
    end
  end

  assign result_o.command   = state_i.mode;
  assign result_o.data_word = {esc_high, esc_low};

endmodule

// ===== rtl/core/serial_command_packet_parser_top.sv =====
// Framed serial command decoder.
//
// rx_i carries one received byte per transaction. A packet is start byte 255,
// command byte (1 anticlockwise, 2 clockwise, 5 position), high byte, low byte
// and an escape byte that can force either data byte to 255. cmd_o carries one
// transaction per completed packet: command code (0..2) and the 16-bit word.
// Any 255 restarts framing; the byte after a completed packet is a start too.
//
// A byte accepted is held in the input register and decoded combinationally
// from it; the result register loads when that byte retires, and the result
// is valid from then on. Throughput: one byte per cycle while the result
// register is not held by a stalled receiver.
//
// Reset clears the framing state, the input valid and the result valid.
// When the receiver stalls, the result waits in its register; non-emitting
// bytes keep flowing, and a byte that would emit a second result waits in
// the input register, which deasserts rx_i.ready until the result leaves.
module serial_command_packet_parser_top
  import scpp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  scpp_in_if.sink    rx_i,
  scpp_out_if.source cmd_o
);

  // input register
  logic         in_valid_q;
  logic [7:0]   in_byte_q;

  // framing state
  scpp_state_t  state_q;
  scpp_state_t  state_d;

  // result register
  logic         out_valid_q;
  scpp_result_t out_q;

  logic         emit;
  scpp_result_t result;
  logic         out_free;
  logic         in_adv;

  scpp_step u_step (
    .state_i  (state_q),
    .byte_i   (in_byte_q),
    .state_o  (state_d),
    .emit_o   (emit),
    .result_o (result)
  );

  assign out_free = !out_valid_q || cmd_o.ready;
  // buffered byte retires unless it needs the result slot and that is full
  assign in_adv   = in_valid_q && (!emit || out_free);
  assign rx_i.ready = !in_valid_q || in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_adv) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_adv && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && emit) begin
      out_q <= result;
    end
  end

  assign cmd_o.valid     = out_valid_q;
  assign cmd_o.command   = out_q.command;
  assign cmd_o.data_word = out_q.data_word;

  // a completed packet leaves the framing in the done phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_adv && emit |=> state_q.phase == PH_DONE)
    else $error("phase not done after packet");

  // a packet byte blocked by a full result slot stays buffered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && emit && !out_free |=> in_valid_q && $stable(in_byte_q))
    else $error("blocked packet byte lost");

  // stall on input only while a byte is buffered and the result slot is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_i.ready |-> in_valid_q && out_valid_q)
    else $error("input stalled without cause");

  // results only come from the escape phase and carry a legal command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_adv && emit |-> state_q.phase == PH_ESC && state_q.mode != 2'd3)
    else $error("result emitted outside escape phase");

endmodule

// ===== tb/tb_serial_command_packet_parser_top.sv =====
`timescale 1ns / 1ps

module tb_serial_command_packet_parser_top
  import scpp_pkg::*;
();

  // Hard stop for a run that hangs. The slowest legal run sends ~550 bytes,
  // with 81% gaps on one side or the other.
  localparam int unsigned CycleLimit  = 200000;
  // Result register loads once the byte leaves the input register; allow slack.
  localparam int unsigned DrainCycles = 10;

  // Packet decoder model plus the queue of commands still owed by the block.
  class packet_scoreboard;
    scpp_phase_e  phase;
    logic         start_seen;
    scpp_mode_e   mode;
    logic [7:0]   high_byte;
    logic [7:0]   low_byte;
    scpp_result_t expected_q[$];
    int unsigned  errors;

    function new();
      phase      = PH_IDLE;
      start_seen = 1'b0;
      mode       = MODE_ACW;
      high_byte  = '0;
      low_byte   = '0;
      errors     = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Advance the framing state by one accepted byte.
    function void note_byte(logic [7:0] b);
      logic         is_cmd;
      scpp_result_t res;
      is_cmd = (b == CmdAcw) || (b == CmdCw) || (b == CmdPos);
      if (b == StartCode || phase == PH_DONE) begin
        // 255 anywhere, or any byte after a finished packet, opens a frame
        phase      = PH_IDLE;
        start_seen = 1'b1;
      end else if (is_cmd && phase == PH_IDLE && start_seen) begin
        start_seen = 1'b0;
        phase      = PH_HIGH;
        if (b == CmdAcw) begin
          mode = MODE_ACW;
        end else if (b == CmdCw) begin
          mode = MODE_CW;
        end else begin
          mode = MODE_POS;
        end
      end else if (phase == PH_HIGH) begin
        high_byte = b;
        phase     = PH_LOW;
      end else if (phase == PH_LOW) begin
        low_byte = b;
        phase    = PH_ESC;
      end else if (phase == PH_ESC) begin
        if (b == EscLow) begin
          low_byte = ForcedByte;
        end else if (b == EscHigh) begin
          high_byte = ForcedByte;
        end else if (b == EscBoth) begin
          high_byte = ForcedByte;
          low_byte  = ForcedByte;
        end
        phase         = PH_DONE;
        res.command   = mode;
        res.data_word = {high_byte, low_byte};
        expected_q.push_back(res);
      end else begin
        // stray byte in idle, or a command with no start pending
        start_seen = 1'b0;
      end
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic [1:0] command, logic [15:0] data_word);
      scpp_result_t exp_res;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected command %0d word %04h", command, data_word));
      end else begin
        exp_res = expected_q.pop_front();
        if (command !== exp_res.command) begin
          report_mismatch($sformatf("command got %0d want %0d", command, exp_res.command));
        end
        if (data_word !== exp_res.data_word) begin
          report_mismatch($sformatf("data_word got %04h want %04h",
                                    data_word, exp_res.data_word));
        end
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  scpp_in_if  rx_if ();
  scpp_out_if cmd_if ();

  serial_command_packet_parser_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .rx_i   (rx_if),
    .cmd_o  (cmd_if)
  );

  packet_scoreboard sb = new();

  // Idle percentages for the current phase of the run.
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned bytes_sent;
  int unsigned cycle_cnt;

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Everything the block sees starts known while reset is held.
  initial begin
    rst_n          <= 1'b0;
    rx_if.valid    <= 1'b0;
    rx_if.rx_byte  <= '0;
    cmd_if.ready   <= 1'b0;
    src_idle_pct    = 0;
    sink_idle_pct   = 0;
    bytes_sent      = 0;
    cycle_cnt       = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Receiver: ready rerolled every cycle against the current stall rate.
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      cmd_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // Transaction monitor. Output is checked before the input of the same
  // edge is noted: a byte taken now cannot produce a result at this edge.
  always @(posedge clk) begin
    if (rst_n) begin
      cycle_cnt++;
      if (cmd_if.valid && cmd_if.ready) begin
        sb.check_result(cmd_if.command, cmd_if.data_word);
      end
      if (rx_if.valid && rx_if.ready) begin
        sb.note_byte(rx_if.rx_byte);
      end
      if (cycle_cnt > CycleLimit) begin
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_cnt, sb.pending());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Offer one byte and hold it until the block takes it. valid only drops
  // when a gap is inserted, so back-to-back bytes never toggle it in one step.
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      rx_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
    bytes_sent++;
  endtask

  function automatic logic [7:0] pick_cmd();
    case ($urandom_range(0, 2))
      0:       return CmdAcw;
      1:       return CmdCw;
      default: return CmdPos;
    endcase
  endfunction

  // Mostly full-range data; now and then a 255 abort or a small value.
  function automatic logic [7:0] pick_data();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return StartCode;
    if (r < 3)  return 8'($urandom_range(0, 5));
    return 8'($urandom_range(0, 255));
  endfunction

  // Escape byte: the fixup codes get most of the weight.
  function automatic logic [7:0] pick_escape();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 12) return 8'($urandom_range(0, 3));
    if (r == 12) return StartCode;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic run_random(input int unsigned goal);
    int unsigned kind;
    int unsigned n;
    while (bytes_sent < goal) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        // well-formed packet; the lead byte is sometimes only a start
        // because it follows a finished packet
        send_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : StartCode);
        send_byte(pick_cmd());
        send_byte(pick_data());
        send_byte(pick_data());
        send_byte(pick_escape());
      end else if (kind < 85) begin
        // truncated or interrupted frame
        send_byte(StartCode);
        send_byte(pick_cmd());
        n = $urandom_range(0, 2);
        repeat (n) send_byte(pick_data());
        send_byte(($urandom_range(0, 1) == 0) ? StartCode : pick_cmd());
      end else begin
        // noise: command-like bytes and stray values
        n = $urandom_range(1, 4);
        repeat (n) begin
          send_byte(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7))
                                                : 8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  // Directed frames: each command, every escape fixup, follow-on byte as
  // start, stray and orphan command bytes, and a 255 aborting a packet.
  logic [7:0] directed_bytes [30] = '{
    8'd255, 8'd1, 8'd0,   8'd0,   8'd0,    // acw, word 0000
    8'd0,   8'd2, 8'd171, 8'd205, 8'd1,    // byte after packet starts; low forced
    8'd5,   8'd5, 8'd18,  8'd52,  8'd2,    // first 5 is a start, not a command
    8'd255, 8'd5, 8'd0,   8'd0,   8'd3,    // both bytes forced
    8'd7,   8'd9, 8'd1,                    // start, stray byte clears it; orphan cmd
    8'd255, 8'd2, 8'd255,                  // 255 as high byte aborts
    8'd1,   8'd128, 8'd254, 8'd4           // no fixup for escape 4
  };

  initial begin
    @(posedge rst_n);
    @(posedge clk);

    // phase 1: sender gaps 34%, receiver stalls 81%
    src_idle_pct  = 34;
    sink_idle_pct = 81;
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    run_random(190);

    // phase 2: roles swapped
    src_idle_pct  = 81;
    sink_idle_pct = 34;
    run_random(370);

    // phase 3: full rate both sides
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_random(550);

    rx_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
